>>> design/ci32_pkg.sv
`default_nettype none

package ci32_pkg;

    localparam int WORD_W    = 32;
    localparam int DIV_STEPS = 32;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_REM = 3'd4;
    localparam logic [2:0] OP_NEG = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_REM_ZERO = 2'd3;

    // One pipeline slot: divider state plus the result of the simple ops.
    typedef struct packed {
        logic [2:0]        op;
        logic              neg_q;
        logic              sign_a;
        logic              b_zero;
        logic [WORD_W-1:0] dvs;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] res;
        logic [1:0]        st;
    } ci32_stage_t;

endpackage

`default_nettype wire

>>> design/checked_i32_alu.sv
// Path: input register, setup stage, divide steps, then sign fixup in the output register.
// Throughput: one transaction per cycle; stages advance independently, so
// bubbles close up and a stalled output freezes only the full tail.
// The depth is set by the 32 restoring divide steps, one quotient bit each.
// Reset (rst_n, asynchronous) clears every stage valid bit; payload registers
// are not reset.
`default_nettype none

module checked_i32_alu
    import ci32_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         operation,
    input  wire logic signed [31:0] operand_a,
    input  wire logic signed [31:0] operand_b,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      result_value,
    output logic [1:0]              status
);

    // Stage 0: input register. Stage 1: add/sub/mul/neg and operand magnitudes.
    // Stages 2 .. LAST-1: divide steps (stage 2 also range-checks the exact
    // result). Stage LAST: sign fixup, divide checks, output register.
    localparam int LAST = DIV_STEPS + 2;

    logic [LAST:0]     v_reg;
    logic [LAST:0]     adv;

    logic [2:0]        op0_reg;
    logic [31:0]       a0_reg;
    logic [31:0]       b0_reg;
    logic [63:0]       exact1_reg;
    logic [63:0]       exact1_next;
    ci32_stage_t       st_reg  [1:LAST-1];
    ci32_stage_t       st_next [1:LAST-1];
    logic [31:0]       res_reg;
    logic [31:0]       res_next;
    logic [1:0]        stat_reg;
    logic [1:0]        stat_next;

    // A stage may load when the output is ready or when it or any later stage has room.
    genvar g;
    generate
        for (g = 0; g <= LAST; g++) begin : g_adv
            assign adv[g] = out_ready || !(&v_reg[LAST:g]);
        end
    endgenerate

    assign in_ready     = adv[0];
    assign out_valid    = v_reg[LAST];
    assign result_value = res_reg;
    assign status       = stat_reg;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic ci32_stage_t div_step(input ci32_stage_t s);
        logic [32:0] trial;
        ci32_stage_t r;
        r     = s;
        trial = {1'b0, s.rem[30:0], s.quo[31]} - {1'b0, s.dvs};
        if (!trial[32])
        begin
            r.rem = trial[31:0];
            r.quo = {s.quo[30:0], 1'b1};
        end
        else
        begin
            r.rem = {s.rem[30:0], s.quo[31]};
            r.quo = {s.quo[30:0], 1'b0};
        end
        return r;
    endfunction

    // Stage 1: exact 64-bit result of add, sub, mul and neg, divider setup.
    always_comb
    begin
        case (op0_reg)
            OP_ADD:  exact1_next = {{32{a0_reg[31]}}, a0_reg} + {{32{b0_reg[31]}}, b0_reg};
            OP_SUB:  exact1_next = {{32{a0_reg[31]}}, a0_reg} - {{32{b0_reg[31]}}, b0_reg};
            OP_MUL:  exact1_next = $signed(a0_reg) * $signed(b0_reg);
            OP_NEG:  exact1_next = 64'd0 - {{32{a0_reg[31]}}, a0_reg};
            default: exact1_next = 64'd0;
        endcase
        st_next[1].op     = op0_reg;
        st_next[1].neg_q  = a0_reg[31] ^ b0_reg[31];
        st_next[1].sign_a = a0_reg[31];
        st_next[1].b_zero = (b0_reg == 32'd0);
        st_next[1].dvs    = b0_reg[31] ? (32'd0 - b0_reg) : b0_reg;
        st_next[1].quo    = a0_reg[31] ? (32'd0 - a0_reg) : a0_reg;
        st_next[1].rem    = 32'd0;
        st_next[1].res    = 32'd0;
        st_next[1].st     = ST_OK;
    end

    // Stage 2: first divide step plus range check of the exact result.
    always_comb
    begin
        st_next[2] = div_step(st_reg[1]);
        case (st_reg[1].op) inside
            OP_ADD, OP_SUB, OP_MUL, OP_NEG:
            begin
                if ((&exact1_reg[63:31]) || !(|exact1_reg[63:31]))
                begin
                    st_next[2].res = exact1_reg[31:0];
                    st_next[2].st  = ST_OK;
                end
                else
                begin
                    st_next[2].res = 32'd0;
                    st_next[2].st  = ST_OVERFLOW;
                end
            end
            default:
            begin
                st_next[2].res = 32'd0;
                st_next[2].st  = ST_OK;
            end
        endcase
    end

    // Remaining divide steps.
    generate
        for (g = 3; g <= LAST - 1; g++) begin : g_div
            assign st_next[g] = div_step(st_reg[g-1]);
        end
    endgenerate

    // Output stage: apply signs and the divide-specific checks.
    always_comb
    begin
        res_next  = st_reg[LAST-1].res;
        stat_next = st_reg[LAST-1].st;
        case (st_reg[LAST-1].op)
            OP_DIV:
            begin
                if (st_reg[LAST-1].b_zero)
                begin
                    res_next  = 32'd0;
                    stat_next = ST_DIV_ZERO;
                end
                else if (!st_reg[LAST-1].neg_q && st_reg[LAST-1].quo[31])
                begin
                    // minimum divided by minus one
                    res_next  = 32'd0;
                    stat_next = ST_OVERFLOW;
                end
                else
                begin
                    res_next  = st_reg[LAST-1].neg_q ? (32'd0 - st_reg[LAST-1].quo)
                                                     : st_reg[LAST-1].quo;
                    stat_next = ST_OK;
                end
            end
            OP_REM:
            begin
                if (st_reg[LAST-1].b_zero)
                begin
                    res_next  = 32'd0;
                    stat_next = ST_REM_ZERO;
                end
                else
                begin
                    res_next  = st_reg[LAST-1].sign_a ? (32'd0 - st_reg[LAST-1].rem)
                                                      : st_reg[LAST-1].rem;
                    stat_next = ST_OK;
                end
            end
            default:
            begin
                res_next  = st_reg[LAST-1].res;
                stat_next = st_reg[LAST-1].st;
            end
        endcase
    end

    // Valid bits: advance with their stage, drop on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k <= LAST; k++)
            begin
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Payload: hold while the stage is stalled.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            op0_reg <= operation;
            a0_reg  <= operand_a;
            b0_reg  <= operand_b;
        end
        if (adv[1])
        begin
            exact1_reg <= exact1_next;
            st_reg[1]  <= st_next[1];
        end
        for (int k = 2; k <= LAST - 1; k++)
        begin
            if (adv[k])
                st_reg[k] <= st_next[k];
        end
        if (adv[LAST])
        begin
            res_reg  <= res_next;
            stat_reg <= stat_next;
        end
    end

    // Any error status must come with a zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (result_value == 32'sd0))
        else $error("error status with nonzero result");

    // An empty output stage means the whole pipe can take a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output stage empty");

    // A freshly accepted transaction is in stage 0 on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[0])
        else $error("accepted transaction lost at input stage");

endmodule

`default_nettype wire
